// ===== hw/rtl/ar3d_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ar3d_pkg
// Types, widths, command codes and shared arithmetic for the 3-D axis rotator.
// ----------------------------------------------------------------------------
package ar3d_pkg;

   localparam int COORD_WIDTH  = 32;
   localparam int ANGLE_WIDTH  = 24;
   localparam int TRIG_STAGES  = 20;

   localparam int TURN_WIDTH   = 32;
   localparam int TRIG_FRAC    = 30;
   localparam int TRIG_WIDTH   = TRIG_FRAC + 2;
   localparam int CORDIC_WIDTH = TURN_WIDTH + 2;
   localparam int CORDIC_DEPTH = TRIG_STAGES + 2;
   localparam int PIPE_DEPTH   = CORDIC_DEPTH + 4;
   localparam int PROD_WIDTH   = COORD_WIDTH + TRIG_WIDTH;
   localparam int SUM_WIDTH    = PROD_WIDTH + 1;

   localparam logic signed [CORDIC_WIDTH-1:0] CORDIC_GAIN = CORDIC_WIDTH'(652032874);
   localparam logic signed [TRIG_WIDTH-1:0]   TRIG_ONE    = TRIG_WIDTH'(64'sd1 <<< TRIG_FRAC);
   localparam logic [TURN_WIDTH-1:0]          QUARTER_TURN = TURN_WIDTH'(1) << (TURN_WIDTH - 2);

   typedef enum logic [1:0] {
      CMD_ROT_X  = 2'd0,
      CMD_ROT_Y  = 2'd1,
      CMD_ROT_Z  = 2'd2,
      CMD_ROT_YZ = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type                       cmd;
      logic signed [COORD_WIDTH-1:0] x_in;
      logic signed [COORD_WIDTH-1:0] y_in;
      logic signed [COORD_WIDTH-1:0] z_in;
      logic [ANGLE_WIDTH-1:0]        angle_first;
      logic [ANGLE_WIDTH-1:0]        angle_second;
   } req_word_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] x_out;
      logic signed [COORD_WIDTH-1:0] y_out;
      logic signed [COORD_WIDTH-1:0] z_out;
   } rsp_word_type;

   // arctangent of 2^-i in units of 2^-32 turn
   function automatic logic [TURN_WIDTH-1:0] atan_turn(input int unsigned idx);
      case (idx)
         0:  return 32'h20000000;
         1:  return 32'h12E4051E;
         2:  return 32'h09FB385B;
         3:  return 32'h051111D4;
         4:  return 32'h028B0D43;
         5:  return 32'h0145D7E1;
         6:  return 32'h00A2F61E;
         7:  return 32'h00517C55;
         8:  return 32'h0028BE53;
         9:  return 32'h00145F2F;
         10: return 32'h000A2F98;
         11: return 32'h000517CC;
         12: return 32'h00028BE6;
         13: return 32'h000145F3;
         14: return 32'h0000A2FA;
         15: return 32'h0000517D;
         16: return 32'h000028BE;
         17: return 32'h0000145F;
         18: return 32'h00000A30;
         19: return 32'h00000518;
         20: return 32'h0000028C;
         21: return 32'h00000146;
         22: return 32'h000000A3;
         23: return 32'h00000051;
         24: return 32'h00000029;
         25: return 32'h00000014;
         26: return 32'h0000000A;
         27: return 32'h00000005;
         28: return 32'h00000003;
         29: return 32'h00000001;
         30: return 32'h00000001;
         default: return '0;
      endcase
   endfunction

   // round half up from Q.30 and saturate to the coordinate range
   function automatic logic signed [COORD_WIDTH-1:0] round_sat(
      input logic signed [SUM_WIDTH-1:0] acc
   );
      logic signed [SUM_WIDTH-1:0] half;
      logic signed [SUM_WIDTH-1:0] rnd;
      logic signed [SUM_WIDTH-1:0] quo;
      logic signed [SUM_WIDTH-1:0] hi_lim;
      logic signed [SUM_WIDTH-1:0] lo_lim;
      half = '0;
      half[TRIG_FRAC-1] = 1'b1;
      hi_lim = '0;
      hi_lim[COORD_WIDTH-2:0] = '1;
      lo_lim = ~hi_lim;
      rnd = acc + half;
      quo = rnd >>> TRIG_FRAC;
      if (quo > hi_lim) begin
         return hi_lim[COORD_WIDTH-1:0];
      end
      if (quo < lo_lim) begin
         return lo_lim[COORD_WIDTH-1:0];
      end
      return quo[COORD_WIDTH-1:0];
   endfunction

endpackage

// ===== hw/rtl/axis_rotation_3d.sv =====
`timescale 1ns / 1ps
// Throughput: one word per cycle while no stall holds the pipeline; two CORDIC pipelines
// run side by side, then two multiply and round stages per rotation step.
// A stall holds only the stages that are full; empty stages still fill.
// Reset clears the stage valid bits only; no result is pending after reset.
// ----------------------------------------------------------------------------
// axis_rotation_3d
// Rotates a Q15.16 3-vector about X, Y, Z, or Y then Z, with rounded and
// saturated outputs.
// ----------------------------------------------------------------------------
module axis_rotation_3d (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  ar3d_pkg::req_word_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ar3d_pkg::rsp_word_type rsp_data
);
   import ar3d_pkg::*;

   localparam int MUL_A = CORDIC_DEPTH;
   localparam int SUM_A = CORDIC_DEPTH + 1;
   localparam int MUL_B = CORDIC_DEPTH + 2;
   localparam int SUM_B = CORDIC_DEPTH + 3;

   logic [PIPE_DEPTH-1:0] valid_ff;
   logic [PIPE_DEPTH-1:0] stage_en;

   for (genvar k = 0; k < PIPE_DEPTH; k++) begin : g_en
      assign stage_en[k] = !rsp_stall || !(&valid_ff[PIPE_DEPTH-1:k]);
   end

   assign req_stall = !stage_en[0];
   assign rsp_valid = valid_ff[PIPE_DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (stage_en[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int k = 1; k < PIPE_DEPTH; k++) begin
            if (stage_en[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   // trig
   logic signed [TRIG_WIDTH-1:0] c1;
   logic signed [TRIG_WIDTH-1:0] s1;
   logic signed [TRIG_WIDTH-1:0] c2;
   logic signed [TRIG_WIDTH-1:0] s2;

   ar3d_cordic u_trig_first (
      .clock    (clock),
      .stage_en (stage_en[CORDIC_DEPTH-1:0]),
      .angle    (req_data.angle_first),
      .cos_out  (c1),
      .sin_out  (s1)
   );

   ar3d_cordic u_trig_second (
      .clock    (clock),
      .stage_en (stage_en[CORDIC_DEPTH-1:0]),
      .angle    (req_data.angle_second),
      .cos_out  (c2),
      .sin_out  (s2)
   );

   // vector and command alongside the cordic
   cmd_type                       line_cmd_ff [CORDIC_DEPTH];
   logic signed [COORD_WIDTH-1:0] line_x_ff [CORDIC_DEPTH];
   logic signed [COORD_WIDTH-1:0] line_y_ff [CORDIC_DEPTH];
   logic signed [COORD_WIDTH-1:0] line_z_ff [CORDIC_DEPTH];

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         line_cmd_ff[0] <= req_data.cmd;
         line_x_ff[0]   <= req_data.x_in;
         line_y_ff[0]   <= req_data.y_in;
         line_z_ff[0]   <= req_data.z_in;
      end
      for (int k = 1; k < CORDIC_DEPTH; k++) begin
         if (stage_en[k]) begin
            line_cmd_ff[k] <= line_cmd_ff[k-1];
            line_x_ff[k]   <= line_x_ff[k-1];
            line_y_ff[k]   <= line_y_ff[k-1];
            line_z_ff[k]   <= line_z_ff[k-1];
         end
      end
   end

   // first rotation: multiply
   cmd_type                       la_cmd;
   logic signed [COORD_WIDTH-1:0] la_p;
   logic signed [COORD_WIDTH-1:0] la_q;
   logic signed [PROD_WIDTH-1:0]  ma_pc_in, ma_qs_in, ma_ps_in, ma_qc_in;
   logic signed [PROD_WIDTH-1:0]  ma_pc_ff, ma_qs_ff, ma_ps_ff, ma_qc_ff;
   cmd_type                       ma_cmd_ff;
   logic signed [COORD_WIDTH-1:0] ma_x_ff, ma_y_ff, ma_z_ff;
   logic signed [TRIG_WIDTH-1:0]  ma_c2_ff, ma_s2_ff;

   always_comb begin
      la_cmd = line_cmd_ff[CORDIC_DEPTH-1];
      case (la_cmd)
         CMD_ROT_X: begin
            la_p = line_y_ff[CORDIC_DEPTH-1];
            la_q = line_z_ff[CORDIC_DEPTH-1];
         end
         CMD_ROT_Y, CMD_ROT_YZ: begin
            la_p = line_z_ff[CORDIC_DEPTH-1];
            la_q = line_x_ff[CORDIC_DEPTH-1];
         end
         CMD_ROT_Z: begin
            la_p = line_x_ff[CORDIC_DEPTH-1];
            la_q = line_y_ff[CORDIC_DEPTH-1];
         end
         default: begin
            la_p = line_x_ff[CORDIC_DEPTH-1];
            la_q = line_y_ff[CORDIC_DEPTH-1];
         end
      endcase
      ma_pc_in = la_p * c1;
      ma_qs_in = la_q * s1;
      ma_ps_in = la_p * s1;
      ma_qc_in = la_q * c1;
   end

   always_ff @(posedge clock) begin
      if (stage_en[MUL_A]) begin
         ma_pc_ff  <= ma_pc_in;
         ma_qs_ff  <= ma_qs_in;
         ma_ps_ff  <= ma_ps_in;
         ma_qc_ff  <= ma_qc_in;
         ma_cmd_ff <= la_cmd;
         ma_x_ff   <= line_x_ff[CORDIC_DEPTH-1];
         ma_y_ff   <= line_y_ff[CORDIC_DEPTH-1];
         ma_z_ff   <= line_z_ff[CORDIC_DEPTH-1];
         ma_c2_ff  <= c2;
         ma_s2_ff  <= s2;
      end
   end

   // first rotation: sum, round, saturate
   logic signed [COORD_WIDTH-1:0] sa_r1, sa_r2;
   logic signed [COORD_WIDTH-1:0] sa_x_in, sa_y_in, sa_z_in;
   logic signed [COORD_WIDTH-1:0] sa_x_ff, sa_y_ff, sa_z_ff;
   cmd_type                       sa_cmd_ff;
   logic signed [TRIG_WIDTH-1:0]  sa_c2_ff, sa_s2_ff;

   always_comb begin
      sa_r1 = round_sat(SUM_WIDTH'(ma_pc_ff) - SUM_WIDTH'(ma_qs_ff));
      sa_r2 = round_sat(SUM_WIDTH'(ma_ps_ff) + SUM_WIDTH'(ma_qc_ff));
      sa_x_in = ma_x_ff;
      sa_y_in = ma_y_ff;
      sa_z_in = ma_z_ff;
      case (ma_cmd_ff)
         CMD_ROT_X: begin
            sa_y_in = sa_r1;
            sa_z_in = sa_r2;
         end
         CMD_ROT_Y, CMD_ROT_YZ: begin
            sa_z_in = sa_r1;
            sa_x_in = sa_r2;
         end
         CMD_ROT_Z: begin
            sa_x_in = sa_r1;
            sa_y_in = sa_r2;
         end
         default: begin
            sa_x_in = ma_x_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (stage_en[SUM_A]) begin
         sa_x_ff   <= sa_x_in;
         sa_y_ff   <= sa_y_in;
         sa_z_ff   <= sa_z_in;
         sa_cmd_ff <= ma_cmd_ff;
         sa_c2_ff  <= ma_c2_ff;
         sa_s2_ff  <= ma_s2_ff;
      end
   end

   // second rotation about z: multiply
   logic signed [PROD_WIDTH-1:0]  mb_pc_in, mb_qs_in, mb_ps_in, mb_qc_in;
   logic signed [PROD_WIDTH-1:0]  mb_pc_ff, mb_qs_ff, mb_ps_ff, mb_qc_ff;
   logic signed [COORD_WIDTH-1:0] mb_x_ff, mb_y_ff, mb_z_ff;
   cmd_type                       mb_cmd_ff;

   always_comb begin
      mb_pc_in = sa_x_ff * sa_c2_ff;
      mb_qs_in = sa_y_ff * sa_s2_ff;
      mb_ps_in = sa_x_ff * sa_s2_ff;
      mb_qc_in = sa_y_ff * sa_c2_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_en[MUL_B]) begin
         mb_pc_ff  <= mb_pc_in;
         mb_qs_ff  <= mb_qs_in;
         mb_ps_ff  <= mb_ps_in;
         mb_qc_ff  <= mb_qc_in;
         mb_x_ff   <= sa_x_ff;
         mb_y_ff   <= sa_y_ff;
         mb_z_ff   <= sa_z_ff;
         mb_cmd_ff <= sa_cmd_ff;
      end
   end

   // second rotation: sum, round, saturate, output word
   rsp_word_type out_in;
   rsp_word_type out_ff;

   always_comb begin
      case (mb_cmd_ff)
         CMD_ROT_YZ: begin
            out_in.x_out = round_sat(SUM_WIDTH'(mb_pc_ff) - SUM_WIDTH'(mb_qs_ff));
            out_in.y_out = round_sat(SUM_WIDTH'(mb_ps_ff) + SUM_WIDTH'(mb_qc_ff));
            out_in.z_out = mb_z_ff;
         end
         default: begin
            out_in.x_out = mb_x_ff;
            out_in.y_out = mb_y_ff;
            out_in.z_out = mb_z_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (stage_en[SUM_B]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_data = out_ff;

endmodule

// ===== hw/rtl/ar3d_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ar3d_cordic
// Pipelined rotation-mode CORDIC giving Q2.30 cosine and sine of a binary angle.
// ----------------------------------------------------------------------------
module ar3d_cordic (
   input  logic                                   clock,
   input  logic [ar3d_pkg::CORDIC_DEPTH-1:0]      stage_en,
   input  logic [ar3d_pkg::ANGLE_WIDTH-1:0]       angle,
   output logic signed [ar3d_pkg::TRIG_WIDTH-1:0] cos_out,
   output logic signed [ar3d_pkg::TRIG_WIDTH-1:0] sin_out
);
   import ar3d_pkg::*;

   localparam logic signed [CORDIC_WIDTH-1:0] ONE_WIDE     = CORDIC_WIDTH'(TRIG_ONE);
   localparam logic signed [CORDIC_WIDTH-1:0] NEG_ONE_WIDE = -ONE_WIDE;
   localparam logic signed [TRIG_WIDTH-1:0]   NEG_ONE      = -TRIG_ONE;

   logic [TURN_WIDTH-1:0] turn;
   logic [TURN_WIDTH-1:0] biased;
   logic [TURN_WIDTH-1:0] folded;
   logic                  flip;

   logic signed [CORDIC_WIDTH-1:0] x_ff [TRIG_STAGES+1];
   logic signed [CORDIC_WIDTH-1:0] y_ff [TRIG_STAGES+1];
   logic signed [CORDIC_WIDTH-1:0] z_ff [TRIG_STAGES+1];
   logic                           flip_ff [TRIG_STAGES+1];

   logic signed [CORDIC_WIDTH-1:0] x_fin;
   logic signed [CORDIC_WIDTH-1:0] y_fin;
   logic signed [TRIG_WIDTH-1:0]   cos_in;
   logic signed [TRIG_WIDTH-1:0]   sin_in;
   logic signed [TRIG_WIDTH-1:0]   cos_ff;
   logic signed [TRIG_WIDTH-1:0]   sin_ff;

   // fold to within a quarter turn of zero
   always_comb begin
      turn   = TURN_WIDTH'(angle) << (TURN_WIDTH - ANGLE_WIDTH);
      biased = turn + QUARTER_TURN;
      flip   = biased[TURN_WIDTH-1];
      folded = turn;
      folded[TURN_WIDTH-1] = turn[TURN_WIDTH-1] ^ flip;
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         x_ff[0]    <= CORDIC_GAIN;
         y_ff[0]    <= '0;
         z_ff[0]    <= CORDIC_WIDTH'(signed'(folded));
         flip_ff[0] <= flip;
      end
   end

   for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_iter
      localparam logic signed [CORDIC_WIDTH-1:0] ATAN = CORDIC_WIDTH'(atan_turn(i));
      logic signed [CORDIC_WIDTH-1:0] dx;
      logic signed [CORDIC_WIDTH-1:0] dy;

      assign dx = y_ff[i] >>> i;
      assign dy = x_ff[i] >>> i;

      always_ff @(posedge clock) begin
         if (stage_en[i+1]) begin
            if (!z_ff[i][CORDIC_WIDTH-1]) begin
               x_ff[i+1] <= x_ff[i] - dx;
               y_ff[i+1] <= y_ff[i] + dy;
               z_ff[i+1] <= z_ff[i] - ATAN;
            end else begin
               x_ff[i+1] <= x_ff[i] + dx;
               y_ff[i+1] <= y_ff[i] - dy;
               z_ff[i+1] <= z_ff[i] + ATAN;
            end
            flip_ff[i+1] <= flip_ff[i];
         end
      end
   end

   // undo the fold, then clamp to plus or minus one
   always_comb begin
      x_fin = flip_ff[TRIG_STAGES] ? -x_ff[TRIG_STAGES] : x_ff[TRIG_STAGES];
      y_fin = flip_ff[TRIG_STAGES] ? -y_ff[TRIG_STAGES] : y_ff[TRIG_STAGES];
      if (x_fin > ONE_WIDE) begin
         cos_in = TRIG_ONE;
      end else if (x_fin < NEG_ONE_WIDE) begin
         cos_in = NEG_ONE;
      end else begin
         cos_in = x_fin[TRIG_WIDTH-1:0];
      end
      if (y_fin > ONE_WIDE) begin
         sin_in = TRIG_ONE;
      end else if (y_fin < NEG_ONE_WIDE) begin
         sin_in = NEG_ONE;
      end else begin
         sin_in = y_fin[TRIG_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[CORDIC_DEPTH-1]) begin
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule
